/* rtl/time_ordered_event_queue_assert.svh */
// Assertion macros for the event queue. Each one is clocked on clk_i and
// disabled while rst_ni is low.
`ifndef TIME_ORDERED_EVENT_QUEUE_ASSERT_SVH
`define TIME_ORDERED_EVENT_QUEUE_ASSERT_SVH

`define TOEQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define TOEQ_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/toeq_pkg.sv */
package toeq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SEARCH = 2'd1,
    S_UPDATE = 2'd2
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic        item_kind;
    logic [7:0]  item_ident;
    logic [31:0] item_time;
    logic [31:0] item_payload;
  } in_t;

  typedef struct packed {
    logic        out_valid;
    logic        out_kind;
    logic [7:0]  out_ident;
    logic [31:0] out_time;
    logic [31:0] out_payload;
    logic        is_empty;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  ident;
    logic [31:0] etime;
    logic [31:0] payload;
  } entry_t;

  typedef struct packed {
    logic    cap;
    logic    cmp;
    logic    push;
    logic    pop;
    logic    res_we;
    status_e status;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       empty;
    logic       full;
  } sts_t;

endpackage

/* rtl/toeq_ctrl.sv */
module toeq_ctrl
  import toeq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  sts_t sts_i,
  output ctl_t ctl_o,
  output logic busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: state_d = S_UPDATE;
      S_UPDATE: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o  = '0;
    ctl_o.status = ST_OK;
    busy_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy_o    = 1'b0;
        ctl_o.cap = start;
      end
      S_SEARCH: begin
        ctl_o.cmp = 1'b1;
      end
      S_UPDATE: begin
        ctl_o.res_we = 1'b1;
        unique case (cmd_e'(sts_i.cmd)) inside
          CMD_APPEND, CMD_INSERT: begin
            if (sts_i.full) begin
              ctl_o.status = ST_FULL;
            end else begin
              ctl_o.push = 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (sts_i.empty) begin
              ctl_o.status = ST_EMPTY;
            end else begin
              ctl_o.pop = 1'b1;
            end
          end
          default: ctl_o.status = ST_OK;
        endcase
      end
      default: busy_o = 1'b1;
    endcase
  end

endmodule

/* rtl/toeq_dp.sv */
module toeq_dp
  import toeq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  item_i,
  input  ctl_t ctl_i,
  output sts_t sts_o,
  output out_t result_o,
  output logic done_o
);

  in_t              item_q;
  entry_t           ent_q [DEPTH];
  logic [CNT_W-1:0] count_q, count_d;
  logic [DEPTH-1:0] gt_q, gt_d;
  logic [DEPTH-1:0] ins_mask;
  entry_t           new_ent;
  out_t             res_q;
  logic             done_q;

  assign new_ent = '{kind:    item_q.item_kind,
                     ident:   item_q.item_ident,
                     etime:   item_q.item_time,
                     payload: item_q.item_payload};

  assign sts_o.cmd   = item_q.command;
  assign sts_o.empty = (count_q == '0);
  assign sts_o.full  = (count_q == CNT_W'(DEPTH));

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      item_q <= item_i;
    end
  end

  // A cell that holds a later time than the new record marks the insert point.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt_d[i] = (CNT_W'(i) < count_q) && (ent_q[i].etime > item_q.item_time) &&
                (item_q.command == CMD_INSERT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cmp) begin
      gt_q <= gt_d;
    end
  end

  // Cells at or past the insert point take part in the shift toward the tail.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ins_mask[i] = (|(gt_q & ({DEPTH{1'b1}} >> (DEPTH - 1 - i)))) ||
                    (CNT_W'(i) >= count_q);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t ent_d;
    logic   first;

    if (g == 0) begin : g_head
      assign first = ins_mask[0];
    end else begin : g_body
      assign first = ins_mask[g] && !ins_mask[g-1];
    end

    always_comb begin
      ent_d = ent_q[g];
      if (ctl_i.push) begin
        if (first) begin
          ent_d = new_ent;
        end else if (ins_mask[g]) begin
          ent_d = ent_q[(g == 0) ? 0 : g - 1];
        end
      end else if (ctl_i.pop) begin
        ent_d = ent_q[(g == DEPTH - 1) ? g : g + 1];
      end
    end

    always_ff @(posedge clk_i) begin
      ent_q[g] <= ent_d;
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl_i.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctl_i.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= ctl_i.res_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_we) begin
      res_q.out_valid   <= ctl_i.pop;
      res_q.out_kind    <= ctl_i.pop ? ent_q[0].kind : 1'b0;
      res_q.out_ident   <= ctl_i.pop ? ent_q[0].ident : 8'd0;
      res_q.out_time    <= ctl_i.pop ? ent_q[0].etime : 32'd0;
      res_q.out_payload <= ctl_i.pop ? ent_q[0].payload : 32'd0;
      res_q.is_empty    <= (count_d == '0);
      res_q.status      <= ctl_i.status;
    end
  end

  assign result_o = res_q;
  assign done_o   = done_q;

endmodule

/* rtl/time_ordered_event_queue.sv */
// Each command runs through capture, a parallel time compare over all cells,
// then the shift update. The result beat is on result_o, marked by done_o,
// for one cycle, and is registered in the shift update step.
// A command is accepted only while busy is low; busy is high while one is in work.
// The receiver cannot stall. Reset empties the queue and clears done_o.
module time_ordered_event_queue
  import toeq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  in_t  item_i,
  output logic busy,
  output logic done_o,
  output out_t result_o
);

  `include "time_ordered_event_queue_assert.svh"

  ctl_t ctl;
  sts_t sts;

  toeq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy_o (busy)
  );

  toeq_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .ctl_i    (ctl),
    .sts_o    (sts),
    .result_o (result_o),
    .done_o   (done_o)
  );

  `TOEQ_NEVER(a_push_pop_excl, ctl.push && ctl.pop, "push and pop issued together")
  `TOEQ_ASSERT(a_done_after_update, done_o |-> $past(ctl.res_we), "beat without update")
  `TOEQ_ASSERT(a_busy_after_start, (start && !busy) |=> busy, "accepted command not in work")
  `TOEQ_NEVER(a_valid_ok, done_o && result_o.out_valid && (result_o.status != ST_OK),
              "returned record with error status")

endmodule

/* verif/toeq_event_checker.sv */
module toeq_event_checker
  import toeq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  logic busy,
  input  in_t  item_i,
  input  logic done_o,
  input  out_t result_o,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  entry_t held_events[$];
  out_t   owed_replies[$];

  // Applies one command to the mirrored queue and returns the reply it owes.
  function automatic out_t apply_command(in_t it);
    out_t   r;
    entry_t e;
    int     pos;
    r = '0;
    r.status = ST_OK;
    case (it.command) inside
      CMD_APPEND, CMD_INSERT: begin
        if (held_events.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          e.kind    = it.item_kind;
          e.ident   = it.item_ident;
          e.etime   = it.item_time;
          e.payload = it.item_payload;
          pos = held_events.size();
          if (it.command == CMD_INSERT) begin
            pos = 0;
            while (pos < held_events.size() && held_events[pos].etime <= it.item_time)
              pos++;
          end
          held_events.insert(pos, e);
        end
      end
      CMD_REMOVE: begin
        if (held_events.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_valid   = 1'b1;
          r.out_kind    = held_events[0].kind;
          r.out_ident   = held_events[0].ident;
          r.out_time    = held_events[0].etime;
          r.out_payload = held_events[0].payload;
          void'(held_events.pop_front());
        end
      end
      default: begin
      end
    endcase
    r.is_empty = (held_events.size() == 0);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      held_events.delete();
      owed_replies.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      // The reply of a command arrives edges after it was taken, so compare first.
      if (done_o) begin
        if (owed_replies.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result beat with none outstanding: %p", $time, result_o);
          fail_count++;
        end else begin
          want = owed_replies.pop_front();
          if (result_o.out_valid !== want.out_valid || result_o.out_kind !== want.out_kind ||
              result_o.out_ident !== want.out_ident || result_o.out_time !== want.out_time ||
              result_o.out_payload !== want.out_payload ||
              result_o.is_empty !== want.is_empty || result_o.status !== want.status) begin
            if (fail_count < 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected valid=%b kind=%b ident=%h time=%h payload=%h empty=%b st=%0d",
                       want.out_valid, want.out_kind, want.out_ident, want.out_time,
                       want.out_payload, want.is_empty, want.status);
              $display("  actual   valid=%b kind=%b ident=%h time=%h payload=%h empty=%b st=%0d",
                       result_o.out_valid, result_o.out_kind, result_o.out_ident,
                       result_o.out_time, result_o.out_payload, result_o.is_empty,
                       result_o.status);
            end
            fail_count++;
          end
        end
      end
      if (start && !busy)
        owed_replies.push_back(apply_command(item_i));
      pending = owed_replies.size();
    end
  end

endmodule

/* verif/tb_time_ordered_event_queue.sv */
module tb_time_ordered_event_queue
  import toeq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni;
  logic start;
  in_t  item_i;
  logic busy;
  logic done_o;
  out_t result_o;
  int   fail_count;
  int   pending;
  bit   idle_on;

  time_ordered_event_queue u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .item_i  (item_i),
    .busy    (busy),
    .done_o  (done_o),
    .result_o(result_o)
  );

  toeq_event_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .item_i    (item_i),
    .done_o    (done_o),
    .result_o  (result_o),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic issue(input logic [1:0] cmd, input logic kind, input logic [7:0] ident,
                       input logic [31:0] tm, input logic [31:0] pay);
    int gap;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= '{command: cmd, item_kind: kind, item_ident: ident, item_time: tm,
                item_payload: pay};
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 3)) inside
      0, 1:    return $urandom_range(0, 15);
      2:       return $urandom;
      default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 7)
                                           : 32'h8000_0000 + $urandom_range(0, 7) - 4;
    endcase
  endfunction

  initial begin
    int sent;
    int burst;
    int add_pct;
    int r;
    rst_ni  = 1'b0;
    start   = 1'b0;
    item_i  = '0;
    idle_on = 1'b1;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Edge cases: empty queue, unsigned time order, equal times, full queue.
    issue(CMD_REMOVE, 1'b1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(CMD_UNUSED, 1'b1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(CMD_INSERT, 1'b1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(CMD_INSERT, 1'b0, 8'h00, 32'h0, 32'h0);
    issue(CMD_INSERT, 1'b1, 8'h01, 32'h0, 32'h1);
    issue(CMD_APPEND, 1'b0, 8'h02, 32'h10, 32'hA5A5_5A5A);
    issue(CMD_INSERT, 1'b1, 8'h03, 32'h8000_0000, 32'h5A5A_A5A5);
    for (int i = 0; i < 11; i++)
      issue(CMD_INSERT, i[0], 8'h10 + i[7:0], 32'h7FFF_FFFF + i * 3 - 15, $urandom);
    issue(CMD_APPEND, 1'b0, 8'hEE, 32'h5, 32'h1234_5678);
    issue(CMD_INSERT, 1'b1, 8'hEF, 32'h0, 32'h8765_4321);
    issue(CMD_UNUSED, 1'b0, 8'h00, 32'h0, 32'h0);
    issue(CMD_REMOVE, 1'b0, 8'h00, 32'h0, 32'h0);
    issue(CMD_REMOVE, 1'b0, 8'h00, 32'h0, 32'h0);

    // Bursts lean toward filling or draining so the queue swings between empty and full.
    sent = 0;
    while (sent < 1200) begin
      burst   = $urandom_range(10, 60);
      idle_on = $urandom_range(0, 2) != 0;
      case ($urandom_range(0, 3))
        0:       add_pct = 85;
        1:       add_pct = 15;
        2:       add_pct = 50;
        default: add_pct = 65;
      endcase
      for (int i = 0; i < burst; i++) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          issue(CMD_UNUSED, 1'($urandom), 8'($urandom), $urandom, $urandom);
        end else begin
          if ($urandom_range(0, 99) < add_pct)
            issue($urandom_range(0, 9) < 7 ? CMD_INSERT : CMD_APPEND, 1'($urandom),
                  8'($urandom), pick_time(), $urandom);
          else
            issue(CMD_REMOVE, 1'($urandom), 8'($urandom), $urandom, $urandom);
          sent++;
        end
      end
    end
    start <= 1'b0;

    wait (pending == 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
